// ----- rtl/priority_ready_queue_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Priority ready queue assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
`define PRIORITY_READY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define PRQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prq assertion failed");

// next-cycle implication
`define PRQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prq assertion failed");

`endif

// ----- rtl/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg
// Shared constants, types and channel layout of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int NUM_LEVELS = 16;
   localparam int NUM_TASKS  = 32;

   localparam int LEVEL_W = $clog2(NUM_LEVELS);
   localparam int TASK_W  = $clog2(NUM_TASKS);
   localparam int TOP_W   = $clog2(NUM_LEVELS + 1);
   localparam int KIND_W  = 2;

   localparam int REQ_FIELDS_W = KIND_W + TASK_W + LEVEL_W;
   localparam int RSP_FIELDS_W = TOP_W + TASK_W + 1;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [TASK_W-1:0]  task_type;
   typedef logic [TOP_W-1:0]   top_type;
   typedef logic [KIND_W-1:0]  kind_type;

   localparam kind_type KIND_TAIL   = 2'd0;
   localparam kind_type KIND_HEAD   = 2'd1;
   localparam kind_type KIND_DELETE = 2'd2;

   localparam top_type TOP_NONE = TOP_W'(NUM_LEVELS);

   // link store read data, captured when a request is accepted
   typedef struct packed {
      task_type  lvl_head;
      task_type  lvl_tail;
      task_type  next;
      task_type  prev;
      level_type tlevel;
   } rd_type;

   // link store write port, one write per table per step
   typedef struct packed {
      logic      head_we;
      level_type head_addr;
      task_type  head_data;
      logic      tail_we;
      level_type tail_addr;
      task_type  tail_data;
      logic      next_we;
      task_type  next_addr;
      task_type  next_data;
      logic      prev_we;
      task_type  prev_addr;
      task_type  prev_data;
      logic      tlev_we;
      task_type  tlev_addr;
      level_type tlev_data;
   } wr_type;

endpackage

// ----- rtl/prq_store.sv -----
// ----------------------------------------------------------------------------
// prq_store
// Head/tail tables per level and link/level tables per task, with registered
// reads and a bypass from the write that commits in the same cycle.
// ----------------------------------------------------------------------------
module prq_store (
   input  logic               clock,
   input  logic               rd_en,
   input  prq_pkg::task_type  rd_task,
   input  prq_pkg::level_type rd_level,
   input  prq_pkg::wr_type    wr,
   input  logic               top_load,
   input  prq_pkg::top_type   top_level,
   output prq_pkg::rd_type    rd,
   output prq_pkg::task_type  top_task
);
   import prq_pkg::*;

   task_type  head_mem [NUM_LEVELS];
   task_type  tail_mem [NUM_LEVELS];
   task_type  next_mem [NUM_TASKS];
   task_type  prev_mem [NUM_TASKS];
   level_type tlev_mem [NUM_TASKS];

   rd_type   rd_ff;
   task_type top_task_ff;

   always_ff @(posedge clock) begin
      if (wr.head_we) begin
         head_mem[wr.head_addr] <= wr.head_data;
      end
      if (wr.tail_we) begin
         tail_mem[wr.tail_addr] <= wr.tail_data;
      end
      if (wr.next_we) begin
         next_mem[wr.next_addr] <= wr.next_data;
      end
      if (wr.prev_we) begin
         prev_mem[wr.prev_addr] <= wr.prev_data;
      end
      if (wr.tlev_we) begin
         tlev_mem[wr.tlev_addr] <= wr.tlev_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff.lvl_head <= (wr.head_we && wr.head_addr == rd_level) ?
                           wr.head_data : head_mem[rd_level];
         rd_ff.lvl_tail <= (wr.tail_we && wr.tail_addr == rd_level) ?
                           wr.tail_data : tail_mem[rd_level];
         rd_ff.next     <= (wr.next_we && wr.next_addr == rd_task) ?
                           wr.next_data : next_mem[rd_task];
         rd_ff.prev     <= (wr.prev_we && wr.prev_addr == rd_task) ?
                           wr.prev_data : prev_mem[rd_task];
         rd_ff.tlevel   <= (wr.tlev_we && wr.tlev_addr == rd_task) ?
                           wr.tlev_data : tlev_mem[rd_task];
      end
   end

   // head of the best level after the step, second read port
   always_ff @(posedge clock) begin
      if (top_load) begin
         if (top_level == TOP_NONE) begin
            top_task_ff <= '0;
         end else if (wr.head_we && top_type'(wr.head_addr) == top_level) begin
            top_task_ff <= wr.head_data;
         end else begin
            top_task_ff <= head_mem[top_level[LEVEL_W-1:0]];
         end
      end
   end

   assign rd       = rd_ff;
   assign top_task = top_task_ff;

endmodule

// ----- rtl/prq_update.sv -----
// ----------------------------------------------------------------------------
// prq_update
// One queue operation: bitmap, queued and head/tail flags, best level and the
// link table writes.
// ----------------------------------------------------------------------------
module prq_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               commit,
   input  prq_pkg::kind_type  kind,
   input  prq_pkg::task_type  task_id,
   input  prq_pkg::level_type priority_req,
   input  prq_pkg::rd_type    rd,
   output prq_pkg::wr_type    wr,
   output prq_pkg::top_type   new_best,
   output logic               error
);
   import prq_pkg::*;

   logic [NUM_LEVELS-1:0] bitmap_ff, bitmap_in;
   logic [NUM_TASKS-1:0]  queued_ff, queued_in;
   logic [NUM_TASKS-1:0]  head_flag_ff, head_flag_in;
   logic [NUM_TASKS-1:0]  tail_flag_ff, tail_flag_in;
   top_type               best_ff, best_in;

   function automatic top_type lowest_set(input logic [NUM_LEVELS-1:0] bits);
      top_type r;
      r = TOP_NONE;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            r = top_type'(i);
         end
      end
      return r;
   endfunction

   always_comb begin
      bitmap_in    = bitmap_ff;
      queued_in    = queued_ff;
      head_flag_in = head_flag_ff;
      tail_flag_in = tail_flag_ff;
      best_in      = best_ff;
      wr           = '0;
      error        = 1'b0;
      if (commit) begin
         unique case (kind)
            KIND_TAIL, KIND_HEAD: begin
               if (queued_ff[task_id]) begin
                  error = 1'b1;
               end else begin
                  wr.tlev_we   = 1'b1;
                  wr.tlev_addr = task_id;
                  wr.tlev_data = priority_req;
                  wr.head_addr = priority_req;
                  wr.head_data = task_id;
                  wr.tail_addr = priority_req;
                  wr.tail_data = task_id;
                  if (kind == KIND_TAIL) begin
                     wr.tail_we            = 1'b1;
                     tail_flag_in[task_id] = 1'b1;
                     head_flag_in[task_id] = !bitmap_ff[priority_req];
                     if (bitmap_ff[priority_req]) begin
                        wr.next_we   = 1'b1;
                        wr.next_addr = rd.lvl_tail;
                        wr.next_data = task_id;
                        wr.prev_we   = 1'b1;
                        wr.prev_addr = task_id;
                        wr.prev_data = rd.lvl_tail;
                        tail_flag_in[rd.lvl_tail] = 1'b0;
                     end else begin
                        wr.head_we = 1'b1;
                     end
                  end else begin
                     wr.head_we            = 1'b1;
                     head_flag_in[task_id] = 1'b1;
                     tail_flag_in[task_id] = !bitmap_ff[priority_req];
                     if (bitmap_ff[priority_req]) begin
                        wr.prev_we   = 1'b1;
                        wr.prev_addr = rd.lvl_head;
                        wr.prev_data = task_id;
                        wr.next_we   = 1'b1;
                        wr.next_addr = task_id;
                        wr.next_data = rd.lvl_head;
                        head_flag_in[rd.lvl_head] = 1'b0;
                     end else begin
                        wr.tail_we = 1'b1;
                     end
                  end
                  bitmap_in[priority_req] = 1'b1;
                  queued_in[task_id]      = 1'b1;
                  if (top_type'(priority_req) < best_ff) begin
                     best_in = top_type'(priority_req);
                  end
               end
            end
            KIND_DELETE: begin
               if (!queued_ff[task_id]) begin
                  error = 1'b1;
               end else begin
                  queued_in[task_id] = 1'b0;
                  wr.head_addr = rd.tlevel;
                  wr.head_data = rd.next;
                  wr.tail_addr = rd.tlevel;
                  wr.tail_data = rd.prev;
                  wr.next_addr = rd.prev;
                  wr.next_data = rd.next;
                  wr.prev_addr = rd.next;
                  wr.prev_data = rd.prev;
                  priority if (head_flag_ff[task_id] && tail_flag_ff[task_id]) begin
                     // last task of its level
                     bitmap_in[rd.tlevel] = 1'b0;
                     if (top_type'(rd.tlevel) == best_ff) begin
                        best_in = lowest_set(bitmap_in);
                     end
                  end else if (head_flag_ff[task_id]) begin
                     wr.head_we            = 1'b1;
                     head_flag_in[rd.next] = 1'b1;
                  end else if (tail_flag_ff[task_id]) begin
                     wr.tail_we            = 1'b1;
                     tail_flag_in[rd.prev] = 1'b1;
                  end else begin
                     wr.next_we = 1'b1;
                     wr.prev_we = 1'b1;
                  end
               end
            end
            default: begin
               error = 1'b0;
            end
         endcase
      end
      new_best = best_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_ff    <= '0;
         queued_ff    <= '0;
         head_flag_ff <= '0;
         tail_flag_ff <= '0;
         best_ff      <= TOP_NONE;
      end else begin
         bitmap_ff    <= bitmap_in;
         queued_ff    <= queued_in;
         head_flag_ff <= head_flag_in;
         tail_flag_ff <= tail_flag_in;
         best_ff      <= best_in;
      end
   end

endmodule

// ----- rtl/priority_ready_queue_unit.sv -----
// An accepted request loads the input register; its step commits and loads
// the result register once no stalled result is held. Throughput: one request
// per cycle unless the result side stalls, set by the read-modify-write
// of the link tables in prq_store with bypass from the committing step.
// Reset clears the level bitmap, queued flags and best level (none ready);
// the link tables keep their contents and are read only once written.
// ----------------------------------------------------------------------------
// priority_ready_queue_unit
// Scheduler ready queue: per-level linked FIFOs of tasks with a level bitmap.
// ----------------------------------------------------------------------------
module priority_ready_queue_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // kind[1:0], task_id[6:2], priority_req[10:7], zero fill
   input  logic [prq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // top_level[4:0], top_task[9:5], error[10], zero fill
   output logic [prq_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import prq_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   kind_type  s1_kind_ff;
   task_type  s1_task_ff;
   level_type s1_pri_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   top_type   rsp_level_ff;
   logic      rsp_error_ff;

   logic      req_fire;
   logic      commit;
   rd_type    rd;
   wr_type    wr;
   top_type   new_best;
   logic      step_error;
   task_type  top_task;
   kind_type  req_kind;
   task_type  req_task;
   level_type req_pri;

   assign req_kind = req_tdata[KIND_W-1:0];
   assign req_task = req_tdata[KIND_W +: TASK_W];
   assign req_pri  = req_tdata[KIND_W+TASK_W +: LEVEL_W];

   assign commit     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || commit;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_kind;
         s1_task_ff <= req_task;
         s1_pri_ff  <= req_pri;
      end
      if (commit) begin
         rsp_level_ff <= new_best;
         rsp_error_ff <= step_error;
      end
   end

   prq_store u_store (
      .clock     (clock),
      .rd_en     (req_fire),
      .rd_task   (req_task),
      .rd_level  (req_pri),
      .wr        (wr),
      .top_load  (commit),
      .top_level (new_best),
      .rd        (rd),
      .top_task  (top_task)
   );

   prq_update u_update (
      .clock        (clock),
      .reset        (reset),
      .commit       (commit),
      .kind         (s1_kind_ff),
      .task_id      (s1_task_ff),
      .priority_req (s1_pri_ff),
      .rd           (rd),
      .wr           (wr),
      .new_best     (new_best),
      .error        (step_error)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_error_ff, top_task, rsp_level_ff});

endmodule

// ----- rtl/prq_checker.sv -----
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks of the ready queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_unit_macros.svh"

module prq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [prq_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [prq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata != '1);

   // a stalled result holds
   `PRQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // no level beyond the "none" code
   `PRQ_ASSERT_IMP(a_level_range, clock, reset, rsp_tvalid, rsp_tdata[4:0] <= prq_pkg::TOP_NONE || !req_seen)
   // empty queue reports task zero
   `PRQ_ASSERT_IMP(a_empty_task, clock, reset, rsp_tvalid && rsp_tdata[4:0] == prq_pkg::TOP_NONE, rsp_tdata[9:5] == 5'd0)
   // nothing is presented right after reset
   `PRQ_ASSERT_IMP(a_reset_idle, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind priority_ready_queue_unit prq_checker u_prq_checker (.*);

// ----- tb/priority_ready_queue_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_ready_queue_unit_tb
// Streams insert and delete requests into the ready queue and checks every
// response against a per-level deque model of the scheduler's ready lists.
// ----------------------------------------------------------------------------
module priority_ready_queue_unit_tb;
   import prq_pkg::*;

   localparam kind_type KIND_UNUSED  = 2'd3;
   localparam int       RANDOM_ITEMS = 550;
   localparam int       CALM_ITEMS   = 100;
   localparam int       HOLD_CYCLES  = 150;
   localparam int       STALL_LIMIT  = 2000;
   localparam int       DRAIN_CYCLES = 10;

   typedef struct packed {
      logic     error;
      task_type top_task;
      top_type  top_level;
   } result_type;

   class ready_queue_scoreboard;
      task_type            level_fifo[NUM_LEVELS][$];
      bit [NUM_TASKS-1:0]  queued;
      level_type           queued_level[NUM_TASKS];
      top_type             best;
      result_type          expected[$];
      int                  mismatches;

      function new();
         queued     = '0;
         best       = TOP_NONE;
         mismatches = 0;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      task report(string what, int got, int want);
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      // apply one accepted request to the model and queue its response
      function void note_request(logic [REQ_DATA_W-1:0] data);
         kind_type   kind;
         task_type   tid;
         level_type  lvl;
         result_type res;
         int         pos;
         kind = data[1:0];
         tid  = data[6:2];
         lvl  = data[10:7];
         res  = '0;
         if (kind == KIND_TAIL || kind == KIND_HEAD) begin
            if (queued[tid]) begin
               res.error = 1'b1;
            end else begin
               if (kind == KIND_TAIL) level_fifo[lvl].push_back(tid);
               else level_fifo[lvl].push_front(tid);
               queued[tid]       = 1'b1;
               queued_level[tid] = lvl;
            end
         end else if (kind == KIND_DELETE) begin
            if (!queued[tid]) begin
               res.error = 1'b1;
            end else begin
               // stored level is used, priority field is don't-care here
               lvl = queued_level[tid];
               pos = 0;
               for (int i = 0; i < level_fifo[lvl].size(); i++)
                  if (level_fifo[lvl][i] == tid) pos = i;
               level_fifo[lvl].delete(pos);
               queued[tid] = 1'b0;
            end
         end
         best = TOP_NONE;
         for (int l = NUM_LEVELS - 1; l >= 0; l--)
            if (level_fifo[l].size() != 0) best = top_type'(l);
         res.top_level = best;
         res.top_task  = (best == TOP_NONE) ? task_type'(0) : level_fifo[best][0];
         expected.push_back(res);
      endfunction

      task check_response(logic [RSP_DATA_W-1:0] data);
         result_type want;
         if (expected.size() == 0) begin
            report("response count", expected.size() + 1, expected.size());
         end else begin
            want = expected.pop_front();
            if (data[4:0] != want.top_level) report("top_level", data[4:0], want.top_level);
            if (data[9:5] != want.top_task) report("top_task", data[9:5], want.top_task);
            if (data[10] != want.error) report("error", data[10], want.error);
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   ready_queue_scoreboard sb = new();
   bit                    calm;
   bit                    hold_request;
   int                    quiet_cycles;

   priority_ready_queue_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_request(kind_type kind, task_type tid,
                                                          level_type lvl);
      logic [REQ_DATA_W-1:0] data;
      data       = '0;
      data[1:0]  = kind;
      data[6:2]  = tid;
      data[10:7] = lvl;
      return data;
   endfunction

   // offer one request, optionally after an idle burst, and wait for acceptance
   task send_request(logic [REQ_DATA_W-1:0] data);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(data);
   endtask

   task send_directed(kind_type kind, int tid, int lvl);
      send_request(pack_request(kind, task_type'(tid), level_type'(lvl)));
   endtask

   // mostly well-formed inserts and deletes, with some raw noise
   task send_random();
      kind_type  kind;
      task_type  tid;
      level_type lvl;
      int        count;
      int        insert_bias;
      kind = kind_type'($urandom_range(0, 3));
      tid  = task_type'($urandom);
      lvl  = level_type'($urandom);
      if ($urandom_range(0, 99) >= 15) begin
         count       = $countones(sb.queued);
         insert_bias = (count < 8) ? 75 : (count > 24) ? 25 : 50;
         if (count == 0 || (count < NUM_TASKS && $urandom_range(0, 99) < insert_bias)) begin
            kind = $urandom_range(0, 1) ? KIND_HEAD : KIND_TAIL;
            do tid = task_type'($urandom); while (sb.queued[tid]);
            if ($urandom_range(0, 2) != 0) lvl = level_type'($urandom_range(0, 3));
         end else begin
            kind = KIND_DELETE;
            do tid = task_type'($urandom); while (!sb.queued[tid]);
         end
      end
      send_request(pack_request(kind, tid, lvl));
   endtask

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      calm         = 1'b0;
      hold_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed(KIND_DELETE, 5, 0);       // delete on empty queue
      send_directed(KIND_UNUSED, 31, 15);     // unused kind, no change
      send_directed(KIND_TAIL, 0, 15);
      send_directed(KIND_TAIL, 31, 15);
      send_directed(KIND_HEAD, 7, 15);
      send_directed(KIND_TAIL, 0, 3);         // already queued
      send_directed(KIND_HEAD, 31, 0);        // already queued
      send_directed(KIND_TAIL, 12, 0);
      send_directed(KIND_HEAD, 3, 0);
      send_directed(KIND_DELETE, 3, 15);      // head of level 0, stale priority field
      send_directed(KIND_DELETE, 12, 0);      // level 0 empties, best moves to 15
      send_directed(KIND_DELETE, 31, 0);      // tail of level 15
      send_directed(KIND_DELETE, 0, 7);       // tail of level 15
      send_directed(KIND_DELETE, 7, 15);      // queue empty again
      send_directed(KIND_DELETE, 7, 15);      // not queued
      send_directed(KIND_TAIL, 1, 8);
      send_directed(KIND_TAIL, 2, 4);
      send_directed(KIND_DELETE, 1, 0);       // non-best level empties
      send_directed(KIND_DELETE, 2, 0);
      send_directed(KIND_UNUSED, 0, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) hold_request = 1'b1;
         if (n == 300) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         send_random();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("priority_ready_queue_unit_tb: PASS");
      end else begin
         $display("priority_ready_queue_unit_tb: FAIL");
      end
      $finish;
   end

   // response side back-pressure
   initial begin
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no request moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("priority_ready_queue_unit_tb: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_store.sv
rtl/prq_update.sv
rtl/priority_ready_queue_unit.sv
rtl/prq_checker.sv
tb/priority_ready_queue_unit_tb.sv
